@@ sv/rgbm_pkg.sv @@
// Shared types and constants for the RGB 3x3 box mean filter.
// No dependencies; imported by every module of the block but rgbm_ram.
package rgbm_pkg;

  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = 3 * CHAN_W;
  localparam int CFG_W   = 11;
  localparam int CFG_INDEX_W = 1;

  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;

  localparam logic [CFG_W-1:0] RESET_ACTIVE_COLUMNS = 11'd128;
  localparam logic [CFG_W-1:0] RESET_ACTIVE_ROWS    = 11'd128;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_COLUMNS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_ROWS    = 1'd1;

  // queue between front and back
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_LEVEL_W = $clog2(Q_DEPTH + 1);

  typedef logic [PIXEL_W-1:0] pixel_t;

  // one column of the window plus what the back end must do with it
  typedef struct packed {
    pixel_t up;
    pixel_t mid;
    pixel_t px;
    logic   emit;
    logic   frame_end;
  } column_pkt_t;

  typedef struct packed {
    logic [Q_LEVEL_W-1:0] level;
    logic                 full;
    logic                 empty;
  } queue_status_t;

endpackage

@@ sv/rgbm_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rgbm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/rgbm_front.sv @@
// Front end: configuration registers, raster counters and the two line stores.
// Depends on rgbm_pkg and rgbm_ram; pushes one window column per pixel.
module rgbm_front import rgbm_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   pix_valid,
  output logic                   pix_ready,
  input  pixel_t                 pix_data,
  output logic                   push_valid,
  input  logic                   push_ready,
  output column_pkt_t            push_pkt
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_CMP_W = (COL_W + 2 > CFG_W) ? COL_W + 2 : CFG_W;
  localparam int ROW_CMP_W = (ROW_W + 2 > CFG_W) ? ROW_W + 2 : CFG_W;

  logic [CFG_W-1:0] active_columns;
  logic [CFG_W-1:0] active_rows;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;

  logic             stage_valid;
  logic [COL_W-1:0] stage_col;
  pixel_t           stage_px;
  logic             stage_emit;
  logic             stage_last;

  logic [COL_CMP_W-1:0] cols_reg;
  logic [COL_CMP_W-1:0] cols_eff;
  logic [ROW_CMP_W-1:0] rows_reg;
  logic [ROW_CMP_W-1:0] rows_eff;
  logic                 last_col;
  logic                 last_row;
  logic                 accept;
  logic                 stage_fire;
  pixel_t               upper_rd;
  pixel_t               middle_rd;

  always_comb begin
    cols_reg = COL_CMP_W'(active_columns);
    rows_reg = ROW_CMP_W'(active_rows);
    if (cols_reg < COL_CMP_W'(3)) begin
      cols_eff = COL_CMP_W'(3);
    end else if (cols_reg > COL_CMP_W'(MAX_COLUMNS)) begin
      cols_eff = COL_CMP_W'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_reg;
    end
    if (rows_reg < ROW_CMP_W'(3)) begin
      rows_eff = ROW_CMP_W'(3);
    end else if (rows_reg > ROW_CMP_W'(MAX_ROWS)) begin
      rows_eff = ROW_CMP_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_reg;
    end
    // wrap as soon as the next count would reach the current size
    last_col = (COL_CMP_W'(col_count) + COL_CMP_W'(1)) >= cols_eff;
    last_row = (ROW_CMP_W'(row_count) + ROW_CMP_W'(1)) >= rows_eff;
  end

  assign pix_ready  = !stage_valid || push_ready;
  assign accept     = pix_valid && pix_ready;
  assign stage_fire = stage_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_columns <= RESET_ACTIVE_COLUMNS;
      active_rows    <= RESET_ACTIVE_ROWS;
      col_count      <= '0;
      row_count      <= '0;
      stage_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ACTIVE_COLUMNS: active_columns <= cfg_data;
          REG_ACTIVE_ROWS:    active_rows    <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        stage_valid <= 1'b1;
        if (last_col) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_count + ROW_W'(1);
        end else begin
          col_count <= col_count + COL_W'(1);
        end
      end else if (stage_fire) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_col  <= col_count;
      stage_px   <= pix_data;
      stage_emit <= (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2));
      stage_last <= last_col && last_row;
    end
  end

  // read at accept; write back the shifted column once the stage moves on
  rgbm_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line_upper (
    .clk     (clk),
    .wr_en   (stage_fire),
    .wr_addr (stage_col),
    .wr_data (middle_rd),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (upper_rd)
  );

  rgbm_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line_middle (
    .clk     (clk),
    .wr_en   (stage_fire),
    .wr_addr (stage_col),
    .wr_data (stage_px),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (middle_rd)
  );

  assign push_valid         = stage_valid;
  assign push_pkt.up        = upper_rd;
  assign push_pkt.mid       = middle_rd;
  assign push_pkt.px        = stage_px;
  assign push_pkt.emit      = stage_emit;
  assign push_pkt.frame_end = stage_last;

endmodule

@@ sv/rgbm_queue.sv @@
// Short column queue between the front and back ends.
// Depends on rgbm_pkg for the entry type and depth.
module rgbm_queue import rgbm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  column_pkt_t   push_pkt,
  output logic          pop_valid,
  input  logic          pop_ready,
  output column_pkt_t   pop_pkt,
  output queue_status_t status
);

  column_pkt_t          entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_LEVEL_W-1:0] level;
  logic                 push;
  logic                 pop;

  assign push_ready = level != Q_LEVEL_W'(Q_DEPTH);
  assign pop_valid  = level != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_pkt    = entries[rd_ptr];

  assign status.level = level;
  assign status.full  = !push_ready;
  assign status.empty = !pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + Q_LEVEL_W'(1);
      end else if (pop && !push) begin
        level <= level - Q_LEVEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

endmodule

@@ sv/rgbm_back.sv @@
// Back end: 3x3 window registers, per-channel sums and the divide by nine.
// Depends on rgbm_pkg; drives the result register of the output stream.
module rgbm_back import rgbm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  column_pkt_t        pop_pkt,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIXEL_W-1:0] out_data,
  output logic               out_last
);

  localparam int SUM_W    = CHAN_W + 4;
  localparam int RECIP_W  = 13;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int DIV_SHIFT = 16;
  // ceil(2^16 / 9); exact floor for every sum of nine 8-bit samples
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

  // index 0 holds column c-2, index 1 holds column c-1
  pixel_t win_up  [2];
  pixel_t win_mid [2];
  pixel_t win_px  [2];

  logic [SUM_W-1:0] sum_next [3];
  logic [SUM_W-1:0] sum      [3];
  logic             sum_valid;
  logic             sum_last;
  logic [PROD_W-1:0] prod    [3];

  logic out_load;
  logic sum_load;
  logic pop;

  assign out_load  = !out_valid || out_ready;
  assign sum_load  = !sum_valid || out_load;
  assign pop_ready = sum_load;
  assign pop       = pop_valid && sum_load;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[ch] = SUM_W'(win_up[0][ch*CHAN_W +: CHAN_W])
                   + SUM_W'(win_mid[0][ch*CHAN_W +: CHAN_W])
                   + SUM_W'(win_px[0][ch*CHAN_W +: CHAN_W])
                   + SUM_W'(win_up[1][ch*CHAN_W +: CHAN_W])
                   + SUM_W'(win_mid[1][ch*CHAN_W +: CHAN_W])
                   + SUM_W'(win_px[1][ch*CHAN_W +: CHAN_W])
                   + SUM_W'(pop_pkt.up[ch*CHAN_W +: CHAN_W])
                   + SUM_W'(pop_pkt.mid[ch*CHAN_W +: CHAN_W])
                   + SUM_W'(pop_pkt.px[ch*CHAN_W +: CHAN_W]);
      prod[ch] = PROD_W'(sum[ch]) * PROD_W'(RECIP_9);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        win_up[k]  <= '0;
        win_mid[k] <= '0;
        win_px[k]  <= '0;
      end
    end else begin
      if (pop) begin
        // every column shifts the window; only inner windows give a result
        win_up[0]  <= win_up[1];
        win_mid[0] <= win_mid[1];
        win_px[0]  <= win_px[1];
        win_up[1]  <= pop_pkt.up;
        win_mid[1] <= pop_pkt.mid;
        win_px[1]  <= pop_pkt.px;
        sum_valid  <= pop_pkt.emit;
      end else if (sum_load) begin
        sum_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= sum_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum[ch] <= sum_next[ch];
      end
      sum_last <= pop_pkt.frame_end;
    end
    if (out_load && sum_valid) begin
      for (int ch = 0; ch < 3; ch++) begin
        out_data[ch*CHAN_W +: CHAN_W] <= prod[ch][DIV_SHIFT +: CHAN_W];
      end
      out_last <= sum_last;
    end
  end

endmodule

@@ sv/rgb_box_mean_filter_3x3.sv @@
// RGB 3x3 box mean filter, top level.
// Depends on rgbm_pkg, rgbm_front, rgbm_queue and rgbm_back (rgbm_ram below the front).
//
// Takes RGB pixels in raster order and returns, for every 3x3 window that
// lies fully inside the frame, the truncated mean of each channel; a frame
// of C x R pixels gives (C-2) x (R-2) results, the last one with tlast set.
// Sustained rate is one pixel per clock unless the output stalls: each line
// store is a dual-port RAM read once and written once per pixel. Results
// pass the line store read, queue, window sum and divide by nine into the
// output register. A stalled output fills the four-entry column queue
// before s_axis_tready drops. Line stores need no clearing after reset.
// Change active_columns and active_rows only between frames; values below
// 3 act as 3 and values above the maximum act as the maximum.
module rgb_box_mean_filter_3x3 import rgbm_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [PIXEL_W-1:0]     s_axis_tdata,   // red_in, green_in, blue_in
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [PIXEL_W-1:0]     m_axis_tdata,   // mean_red, mean_green, mean_blue
  output logic                   m_axis_tlast    // frame_end
);

  logic          push_valid;
  logic          push_ready;
  column_pkt_t   push_pkt;
  logic          pop_valid;
  logic          pop_ready;
  column_pkt_t   pop_pkt;
  queue_status_t q_status;

  rgbm_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_valid  (s_axis_tvalid),
    .pix_ready  (s_axis_tready),
    .pix_data   (s_axis_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_pkt   (push_pkt)
  );

  rgbm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_pkt   (push_pkt),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_pkt    (pop_pkt),
    .status     (q_status)
  );

  rgbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_pkt   (pop_pkt),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  // a column held by the front end must not change while the queue is full
  a_push_hold: assert property (@(posedge clk) disable iff (rst)
    push_valid && !push_ready |=> push_valid && $stable(push_pkt))
    else $error("front column changed while queue was full");

  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    (q_status.level <= Q_LEVEL_W'(Q_DEPTH))
      && (q_status.full == (q_status.level == Q_LEVEL_W'(Q_DEPTH)))
      && (q_status.empty == (q_status.level == '0)))
    else $error("queue level out of range or flags inconsistent");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not ready and empty after reset");

  // input stalls only when the front stage waits on a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> push_valid && q_status.full)
    else $error("input stalled without a full queue");

endmodule
